@@ rtl/utf8sbe_pkg.sv @@
// Package for the UTF-8 sanitizer: buffer and handshake types, codes,
// lead-byte decode, prefix classification and escape-byte encoding.
// No dependencies.
package utf8sbe_pkg;

    localparam logic [19:0] ESC_BASE  = 20'hFFF00;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    // Classification codes. A complete character is coded by its length, 1 to 4.
    localparam logic [2:0] CLS_BAD  = 3'd0;
    localparam logic [2:0] CLS_PART = 3'd5;

    // Byte 0 is the oldest byte.
    typedef logic [3:0][7:0] ubuf_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       escaped;
        logic       last;
    } scan_emit_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < 8'h80)
        begin
            len = 3'd1;
        end
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            len = 3'd2;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            len = 3'd3;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Classify the first n bytes (n from 1 to 4) of a buffer.
    function automatic logic [2:0] classify(input ubuf_t b, input logic [2:0] n);
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       bad;
        logic [2:0] res;
        len = lead_length(b[0]);
        bad = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            lo = 8'h80;
            hi = 8'hBF;
            if (i == 1)
            begin
                if (b[0] == 8'hE0)
                begin
                    lo = 8'hA0;
                end
                else if (b[0] == 8'hED)
                begin
                    hi = 8'h9F;
                end
                else if (b[0] == 8'hF0)
                begin
                    lo = 8'h90;
                end
                else if (b[0] == 8'hF4)
                begin
                    hi = 8'h8F;
                end
            end
            if ((3'(i) < len) && (3'(i) < n))
            begin
                if (b[i] < lo || b[i] > hi)
                begin
                    bad = 1'b1;
                end
            end
        end
        if (len == 3'd0 || bad)
        begin
            res = CLS_BAD;
        end
        else if (n >= len)
        begin
            res = len;
        end
        else
        begin
            res = CLS_PART;
        end
        return res;
    endfunction

    // One byte of the 4-byte encoding of ESC_BASE plus the raw byte.
    function automatic logic [7:0] esc_byte(input logic [7:0] b, input logic [1:0] idx);
        logic [19:0] cp;
        logic [7:0]  res;
        cp = ESC_BASE | {12'd0, b & BYTE_MASK};
        case (idx)
            2'd0:    res = {6'b111100, cp[19:18]};
            2'd1:    res = {2'b10, cp[17:12]};
            2'd2:    res = {2'b10, cp[11:6]};
            2'd3:    res = {2'b10, cp[5:0]};
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/utf8sbe_if.sv @@
// Valid/ready channel interfaces for the UTF-8 sanitizer: raw byte input
// and sanitized byte output. No dependencies.
interface utf8sbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8sbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       escaped;
    logic       out_last;

    modport source (output valid, output out_byte, output escaped, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input escaped, input out_last,
                    output ready);
endinterface

@@ rtl/utf8_sanitize_byte_escape_unit.sv @@
// Top level of the UTF-8 sanitizer with invalid-byte escapes.
// Depends on utf8sbe_pkg, utf8sbe_if and utf8sbe_scan.
//
//   channel   dir   payload                          transaction
//   in_ch     in    in_byte[7:0], in_last            one raw text byte
//   out_ch    out   out_byte[7:0], escaped, out_last one sanitized byte
//
// Rate: one output byte per cycle while out_ch.ready keeps up; a valid
// character of L bytes emits its L bytes, an escaped byte its 4-byte
// encoding, set by the single scanner emit path. A byte is accepted in
// the same cycle the previous buffered bytes finish, so plain text flows
// at one byte per cycle unstalled (scanner buffer, then output register).
// Reset clears the held-byte count and the output valid; no clearing pass.
// Stalls: out_ch.ready low holds the output register and the scanner; input
// is still taken while the scanner holds only an unfinished sequence.
module utf8_sanitize_byte_escape_unit (
    input  logic          clk,
    input  logic          rst_n,
    utf8sbe_in_if.sink    in_ch,
    utf8sbe_out_if.source out_ch
);
    import utf8sbe_pkg::*;

    scan_emit_t emit;
    logic       emit_ready;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       escaped_reg;
    logic       out_last_reg;

    // Free output slot: empty, or being drained this cycle.
    assign emit_ready = !out_valid_reg || out_ch.ready;

    utf8sbe_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_byte    (in_ch.in_byte),
        .in_last    (in_ch.in_last),
        .in_ready   (in_ch.ready),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    // Output register: advance when a byte is emitted, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit.valid)
        begin
            out_byte_reg <= emit.data;
            escaped_reg  <= emit.escaped;
            out_last_reg <= emit.last;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.escaped  = escaped_reg;
    assign out_ch.out_last = out_last_reg;
endmodule

@@ rtl/utf8sbe_scan.sv @@
// Scanner of the UTF-8 sanitizer: holds the unfinished sequence, classifies
// it and emits one output byte per cycle unstalled. Depends on utf8sbe_pkg.
module utf8sbe_scan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    output logic                    in_ready,
    input  logic                    emit_ready,
    output utf8sbe_pkg::scan_emit_t emit
);
    import utf8sbe_pkg::*;

    ubuf_t      buf_reg, buf_next;
    logic [2:0] n_reg, n_next;
    logic [1:0] pos_reg, pos_next;
    logic       last_reg, last_next;

    logic [2:0] cls;
    logic       is_char;
    logic       busy;
    logic       step_done;
    logic [2:0] shift;
    ubuf_t      buf_sh;
    logic [2:0] n_sh;
    logic [2:0] cls_sh;
    logic       busy_sh;
    logic       emitting;
    ubuf_t      base_buf;
    logic [2:0] base_n;
    logic       in_fire;

    always_comb
    begin
        cls       = classify(buf_reg, n_reg);
        is_char   = (cls != CLS_BAD) && (cls != CLS_PART);
        busy      = (n_reg != 3'd0) && ((cls != CLS_PART) || last_reg);
        shift     = is_char ? cls : 3'd1;
        step_done = is_char ? (pos_reg == 2'(cls - 3'd1)) : (pos_reg == 2'd3);

        // Drop the consumed bytes from the front.
        case (shift)
            3'd1:    buf_sh = {8'h00, buf_reg[3:1]};
            3'd2:    buf_sh = {16'h0000, buf_reg[3:2]};
            3'd3:    buf_sh = {24'h000000, buf_reg[3]};
            default: buf_sh = '0;
        endcase
        n_sh    = n_reg - shift;
        cls_sh  = classify(buf_sh, n_sh);
        busy_sh = (n_sh != 3'd0) && ((cls_sh != CLS_PART) || last_reg);

        emitting      = busy && emit_ready;
        emit.valid    = busy;
        emit.data     = is_char ? buf_reg[pos_reg] : esc_byte(buf_reg[0], pos_reg);
        emit.escaped  = !is_char;
        emit.last     = last_reg && step_done && (n_sh == 3'd0);

        // Take a new byte once the buffer has nothing left to emit.
        if (emitting && step_done)
        begin
            base_buf = buf_sh;
            base_n   = n_sh;
            in_ready = !busy_sh;
        end
        else
        begin
            base_buf = buf_reg;
            base_n   = n_reg;
            in_ready = !busy;
        end
        in_fire = in_valid && in_ready;

        buf_next  = buf_reg;
        n_next    = n_reg;
        pos_next  = pos_reg;
        last_next = last_reg;
        if (emitting)
        begin
            if (step_done)
            begin
                buf_next = buf_sh;
                n_next   = n_sh;
                pos_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
        if (in_fire)
        begin
            buf_next               = base_buf;
            buf_next[base_n[1:0]]  = in_byte;
            n_next                 = base_n + 3'd1;
            last_next              = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= 3'd0;
            pos_reg  <= 2'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            n_reg    <= n_next;
            pos_reg  <= pos_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    a_n_range: assert property (@(posedge clk) disable iff (!rst_n) n_reg <= 3'd4)
        else $error("held byte count out of range");
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n) !busy |-> pos_reg == 2'd0)
        else $error("emit position set while nothing to emit");
    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> base_n <= 3'd3)
        else $error("new byte loaded into a full buffer");
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emitting && emit.last) |=> n_reg <= 3'd1)
        else $error("buffer not flushed after end of string");
endmodule
